// ----- hdl/pts_pkg.sv -----
// Shared types and constants of the periodic task scheduler.
`default_nettype none
package pts_pkg;

  // Most due results emitted for one tick item.
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned DEF_MAX_TASKS = 16;

  localparam int unsigned TIME_W = 48;
  localparam int unsigned WORD_W = 32;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_WAKE   = 2'd2,
    KIND_TICK   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_FULL    = 3'd2,
    ST_DUE     = 3'd3,
    ST_NONE    = 3'd4
  } status_e;

endpackage
`default_nettype wire

// ----- hdl/periodic_task_scheduler_top.sv -----
// Periodic task scheduler: task table, id lookup scan and due-order selection.
// Add, remove and wake each run one table scan; an invalid add and a zero target id answer
// without a scan. A tick runs one scan per due task plus a closing scan that finds
// nothing; at the 16-result limit a flush state ends it instead of the closing scan.
// Results are strobed for one cycle on done_o; the next item can go in with the last one.
// rst_ni clears valid bits and counters at once (id counter to one); table contents stay.
`default_nettype none
module periodic_task_scheduler_top #(
  parameter int unsigned MAX_TASKS = pts_pkg::DEF_MAX_TASKS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind_i,
  input  wire logic [47:0] now_ms_i,
  input  wire logic [31:0] period_ms_i,
  input  wire logic        start_now_i,
  input  wire logic [31:0] target_id_i,
  input  wire logic [31:0] handler_ref_i,
  input  wire logic [31:0] handler_arg_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [31:0]      result_id_o,
  output logic [31:0]      due_ref_o,
  output logic [31:0]      due_arg_o,
  output logic             last_o
);

  localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);
  localparam int unsigned NW = $clog2(pts_pkg::MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_e;

  state_e state_q;

  // Table storage; one shared write address, write enables per field group.
  logic [31:0] mem_id  [MAX_TASKS];
  logic [31:0] mem_per [MAX_TASKS];
  logic [47:0] mem_dl  [MAX_TASKS];
  logic [31:0] mem_ord [MAX_TASKS];
  logic [31:0] mem_ref [MAX_TASKS];
  logic [31:0] mem_arg [MAX_TASKS];

  logic [MAX_TASKS-1:0] valid_q, picked_q;
  logic [31:0] id_cnt_q, ord_cnt_q;

  // Latched item.
  logic [1:0]  kind_q;
  logic [47:0] now_q;
  logic [31:0] per_q, ref_q, arg_q, key_q, next_q;
  logic        start_now_q;

  // Scan control and read pipeline.
  logic [CW-1:0] cnt_q;
  logic          rd_vld_q;
  logic [IW-1:0] rd_idx_q;
  logic [31:0]   rd_id_q, rd_per_q, rd_ord_q, rd_ref_q, rd_arg_q;
  logic [47:0]   rd_dl_q;

  logic          found_v_q, free_v_q;
  logic [IW-1:0] found_idx_q, free_idx_q;

  // Tick selection.
  logic          best_v_q;
  logic [IW-1:0] best_idx_q;
  logic [47:0]   best_dl_q;
  logic [31:0]   best_ord_q, best_id_q, best_per_q, best_ref_q, best_arg_q;
  logic [NW-1:0] n_q;
  logic          pend_v_q;
  logic [31:0]   pend_id_q, pend_ref_q, pend_arg_q;

  logic [31:0] cand, cand_next;
  logic        accept, scan_end, hit, free_hit, due_ok, better;
  logic [48:0] sum;
  logic [31:0] sat_per;
  logic [47:0] sat_dl;

  // Write port controls.
  logic          we_new, we_dl, we_ord;
  logic [IW-1:0] waddr;
  logic [47:0]   wdl;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // Candidate id, skipping zero.
  always_comb begin
    if (id_cnt_q == '0) begin
      cand      = id_cnt_q + 32'd1;
      cand_next = id_cnt_q + 32'd2;
    end else begin
      cand      = id_cnt_q;
      cand_next = id_cnt_q + 32'd1;
    end
  end

  // Shared saturating deadline adder.
  assign sat_per = (kind_q == pts_pkg::KIND_TICK) ? best_per_q : per_q;
  assign sum     = {1'b0, now_q} + {17'd0, sat_per};
  assign sat_dl  = sum[48] ? '1 : sum[47:0];

  // Per-entry tests on the registered read data.
  assign scan_end = (cnt_q == CW'(MAX_TASKS)) && !rd_vld_q;
  assign hit      = rd_vld_q && valid_q[rd_idx_q] && (rd_id_q == key_q);
  assign free_hit = rd_vld_q && !valid_q[rd_idx_q];
  assign due_ok   = rd_vld_q && valid_q[rd_idx_q] && !picked_q[rd_idx_q] && (rd_dl_q <= now_q);
  assign better   = !best_v_q || (rd_dl_q < best_dl_q) ||
                    ((rd_dl_q == best_dl_q) && (rd_ord_q < best_ord_q));

  // Table write decisions at the end of a scan.
  always_comb begin
    we_new = 1'b0;
    we_dl  = 1'b0;
    we_ord = 1'b0;
    waddr  = found_idx_q;
    wdl    = '0;
    if (state_q == S_SCAN && scan_end) begin
      unique case (pts_pkg::kind_e'(kind_q))
        pts_pkg::KIND_ADD: begin
          if (found_v_q) begin
            we_ord = 1'b1;
          end else if (free_v_q) begin
            waddr  = free_idx_q;
            we_new = 1'b1;
            we_dl  = 1'b1;
            we_ord = 1'b1;
            wdl    = start_now_q ? now_q : sat_dl;
          end
        end
        pts_pkg::KIND_WAKE: begin
          we_dl  = found_v_q;
          we_ord = found_v_q;
        end
        pts_pkg::KIND_TICK: begin
          waddr  = best_idx_q;
          we_dl  = best_v_q;
          we_ord = best_v_q;
          wdl    = sat_dl;
        end
        default: ;
      endcase
    end
  end

  // Table memory: write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_new) begin
      mem_id[waddr]  <= key_q;
      mem_per[waddr] <= per_q;
      mem_ref[waddr] <= ref_q;
      mem_arg[waddr] <= arg_q;
    end
    if (we_dl) begin
      mem_dl[waddr] <= wdl;
    end
    if (we_ord) begin
      mem_ord[waddr] <= ord_cnt_q;
    end
    rd_id_q  <= mem_id[cnt_q[IW-1:0]];
    rd_per_q <= mem_per[cnt_q[IW-1:0]];
    rd_dl_q  <= mem_dl[cnt_q[IW-1:0]];
    rd_ord_q <= mem_ord[cnt_q[IW-1:0]];
    rd_ref_q <= mem_ref[cnt_q[IW-1:0]];
    rd_arg_q <= mem_arg[cnt_q[IW-1:0]];
  end

  // Sequencer, counters and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      picked_q  <= '0;
      id_cnt_q  <= 32'd1;
      ord_cnt_q <= '0;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      found_v_q <= 1'b0;
      free_v_q  <= 1'b0;
      best_v_q  <= 1'b0;
      pend_v_q  <= 1'b0;
      n_q       <= '0;
      done_o    <= 1'b0;
      kind_q    <= '0;
    end else begin
      done_o <= 1'b0;
      if (we_ord) begin
        ord_cnt_q <= ord_cnt_q + 32'd1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            kind_q      <= kind_i;
            now_q       <= now_ms_i;
            per_q       <= period_ms_i;
            start_now_q <= start_now_i;
            ref_q       <= handler_ref_i;
            arg_q       <= handler_arg_i;
            next_q      <= cand_next;
            key_q       <= (kind_i == pts_pkg::KIND_ADD) ? cand : target_id_i;
            cnt_q       <= '0;
            rd_vld_q    <= 1'b0;
            found_v_q   <= 1'b0;
            free_v_q    <= 1'b0;
            best_v_q    <= 1'b0;
            pend_v_q    <= 1'b0;
            picked_q    <= '0;
            n_q         <= '0;
            status_o    <= pts_pkg::ST_OK;
            result_id_o <= '0;
            due_ref_o   <= '0;
            due_arg_o   <= '0;
            last_o      <= 1'b1;
            priority if (kind_i == pts_pkg::KIND_ADD &&
                         (period_ms_i == '0 || handler_ref_i == '0)) begin
              done_o   <= 1'b1;
              status_o <= pts_pkg::ST_INVALID;
            end else if (kind_i != pts_pkg::KIND_ADD && kind_i != pts_pkg::KIND_TICK &&
                         target_id_i == '0) begin
              done_o <= 1'b1;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Issue one read a cycle, evaluate the entry read the cycle before.
          rd_vld_q <= (cnt_q != CW'(MAX_TASKS));
          rd_idx_q <= cnt_q[IW-1:0];
          if (cnt_q != CW'(MAX_TASKS)) begin
            cnt_q <= cnt_q + CW'(1);
          end
          if (hit && !found_v_q) begin
            found_v_q   <= 1'b1;
            found_idx_q <= rd_idx_q;
          end
          if (free_hit && !free_v_q) begin
            free_v_q   <= 1'b1;
            free_idx_q <= rd_idx_q;
          end
          if (due_ok && better) begin
            best_v_q   <= 1'b1;
            best_idx_q <= rd_idx_q;
            best_dl_q  <= rd_dl_q;
            best_ord_q <= rd_ord_q;
            best_id_q  <= rd_id_q;
            best_per_q <= rd_per_q;
            best_ref_q <= rd_ref_q;
            best_arg_q <= rd_arg_q;
          end
          if (scan_end) begin
            unique case (pts_pkg::kind_e'(kind_q))
              pts_pkg::KIND_ADD: begin
                state_q <= S_IDLE;
                done_o  <= 1'b1;
                if (found_v_q) begin
                  id_cnt_q    <= next_q;
                  result_id_o <= key_q;
                end else if (free_v_q) begin
                  id_cnt_q             <= next_q;
                  valid_q[free_idx_q]  <= 1'b1;
                  result_id_o          <= key_q;
                end else begin
                  status_o <= pts_pkg::ST_FULL;
                end
              end
              pts_pkg::KIND_REMOVE: begin
                state_q <= S_IDLE;
                done_o  <= 1'b1;
                if (found_v_q) begin
                  valid_q[found_idx_q] <= 1'b0;
                end
              end
              pts_pkg::KIND_WAKE: begin
                state_q <= S_IDLE;
                done_o  <= 1'b1;
                if (!found_v_q) begin
                  status_o <= pts_pkg::ST_INVALID;
                end
              end
              pts_pkg::KIND_TICK: begin
                if (best_v_q) begin
                  // The previous pick goes out now; this one waits to learn if it is final.
                  if (pend_v_q) begin
                    done_o      <= 1'b1;
                    status_o    <= pts_pkg::ST_DUE;
                    result_id_o <= pend_id_q;
                    due_ref_o   <= pend_ref_q;
                    due_arg_o   <= pend_arg_q;
                    last_o      <= 1'b0;
                  end
                  pend_v_q             <= 1'b1;
                  pend_id_q            <= best_id_q;
                  pend_ref_q           <= best_ref_q;
                  pend_arg_q           <= best_arg_q;
                  picked_q[best_idx_q] <= 1'b1;
                  n_q                  <= n_q + NW'(1);
                  best_v_q             <= 1'b0;
                  cnt_q                <= '0;
                  if (n_q + NW'(1) == NW'(pts_pkg::MAX_RESULTS)) begin
                    state_q <= S_FLUSH;
                  end
                end else begin
                  state_q <= S_IDLE;
                  done_o  <= 1'b1;
                  last_o  <= 1'b1;
                  if (pend_v_q) begin
                    status_o    <= pts_pkg::ST_DUE;
                    result_id_o <= pend_id_q;
                    due_ref_o   <= pend_ref_q;
                    due_arg_o   <= pend_arg_q;
                  end else begin
                    status_o <= pts_pkg::ST_NONE;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_FLUSH: begin
          // Result limit reached: the held pick is the final result.
          state_q     <= S_IDLE;
          pend_v_q    <= 1'b0;
          done_o      <= 1'b1;
          status_o    <= pts_pkg::ST_DUE;
          result_id_o <= pend_id_q;
          due_ref_o   <= pend_ref_q;
          due_arg_o   <= pend_arg_q;
          last_o      <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // Only due results can be followed by more results of the same item.
  a_nondue_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != pts_pkg::ST_DUE |-> last_o)
    else $error("non-due result without last");

  // A non-final result means the item is still being worked on.
  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !last_o |-> busy)
    else $error("non-final result while idle");

  // The number of picks in one tick never exceeds the result limit.
  a_pick_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(pts_pkg::MAX_RESULTS))
    else $error("tick pick count overflow");

  // A successful add never hands out id zero.
  a_nonzero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == pts_pkg::ST_OK && kind_q == pts_pkg::KIND_ADD && $past(busy)
    |-> result_id_o != '0)
    else $error("add returned id zero");
`endif

endmodule
`default_nettype wire

// ----- dv/periodic_task_scheduler_checker.sv -----
// Checker for the periodic task scheduler: table predictor and result scoreboard.
`timescale 1ns / 100ps
module periodic_task_scheduler_checker #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  kind_i,
  input  wire logic [47:0] now_ms_i,
  input  wire logic [31:0] period_ms_i,
  input  wire logic        start_now_i,
  input  wire logic [31:0] target_id_i,
  input  wire logic [31:0] handler_ref_i,
  input  wire logic [31:0] handler_arg_i,
  input  wire logic        done_o,
  input  wire logic [2:0]  status_o,
  input  wire logic [31:0] result_id_o,
  input  wire logic [31:0] due_ref_o,
  input  wire logic [31:0] due_arg_o,
  input  wire logic        last_o,
  output int               fail_count,
  output int               pending_count,
  output int               due_seen,
  output int               full_seen
);

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] id;
    logic [31:0] ref_v;
    logic [31:0] arg;
    logic        last;
  } sched_result_t;

  localparam logic [47:0] TIME_MAX = '1;

  // Predicted task table.
  logic        tv [MAX_TASKS];
  logic [31:0] tid [MAX_TASKS];
  logic [31:0] tper [MAX_TASKS];
  logic [47:0] tdl [MAX_TASKS];
  logic [31:0] tord [MAX_TASKS];
  logic [31:0] tref [MAX_TASKS];
  logic [31:0] targ [MAX_TASKS];
  logic [31:0] next_id;
  logic [31:0] next_order;

  sched_result_t expected_q[$];

  assign pending_count = expected_q.size();

  function automatic logic [47:0] sat_add(logic [47:0] t, logic [31:0] p);
    logic [48:0] s;
    s = {1'b0, t} + {17'd0, p};
    return s[48] ? TIME_MAX : s[47:0];
  endfunction

  function automatic int lookup_id(logic [31:0] id);
    for (int i = 0; i < MAX_TASKS; i++)
      if (tv[i] && tid[i] == id) return i;
    return -1;
  endfunction

  function automatic void push_result(pts_pkg::status_e st, logic [31:0] id, logic [31:0] r,
                                      logic [31:0] a, logic l);
    sched_result_t e;
    e.status = st; e.id = id; e.ref_v = r; e.arg = a; e.last = l;
    expected_q = {expected_q, e};
  endfunction

  // Apply one accepted item to the predicted table and queue its results.
  task automatic predict_item();
    logic [31:0] cand, nxt;
    int slot, best, n;
    logic picked [MAX_TASKS];
    case (pts_pkg::kind_e'(kind_i))
      pts_pkg::KIND_ADD: begin
        if (period_ms_i == 0 || handler_ref_i == 0) begin
          push_result(pts_pkg::ST_INVALID, 0, 0, 0, 1);
        end else begin
          cand = next_id;
          nxt = next_id + 1;
          if (cand == 0) begin
            cand = nxt;
            nxt = nxt + 1;
          end
          slot = lookup_id(cand);
          if (slot >= 0) begin
            next_id = nxt;
            tord[slot] = next_order++;
            push_result(pts_pkg::ST_OK, cand, 0, 0, 1);
          end else begin
            slot = -1;
            for (int i = MAX_TASKS - 1; i >= 0; i--)
              if (!tv[i]) slot = i;
            if (slot < 0) begin
              full_seen++;
              push_result(pts_pkg::ST_FULL, 0, 0, 0, 1);
            end else begin
              next_id = nxt;
              tv[slot] = 1;
              tid[slot] = cand;
              tper[slot] = period_ms_i;
              tdl[slot] = start_now_i ? now_ms_i : sat_add(now_ms_i, period_ms_i);
              tref[slot] = handler_ref_i;
              targ[slot] = handler_arg_i;
              tord[slot] = next_order++;
              push_result(pts_pkg::ST_OK, cand, 0, 0, 1);
            end
          end
        end
      end
      pts_pkg::KIND_REMOVE: begin
        if (target_id_i != 0) begin
          slot = lookup_id(target_id_i);
          if (slot >= 0) tv[slot] = 0;
        end
        push_result(pts_pkg::ST_OK, 0, 0, 0, 1);
      end
      pts_pkg::KIND_WAKE: begin
        if (target_id_i == 0) begin
          push_result(pts_pkg::ST_OK, 0, 0, 0, 1);
        end else begin
          slot = lookup_id(target_id_i);
          if (slot < 0) begin
            push_result(pts_pkg::ST_INVALID, 0, 0, 0, 1);
          end else begin
            tdl[slot] = 0;
            tord[slot] = next_order++;
            push_result(pts_pkg::ST_OK, 0, 0, 0, 1);
          end
        end
      end
      default: begin
        // Tick: emit due entries by deadline, then schedule order.
        n = 0;
        for (int i = 0; i < MAX_TASKS; i++) picked[i] = 0;
        while (n < pts_pkg::MAX_RESULTS) begin
          best = -1;
          for (int i = 0; i < MAX_TASKS; i++) begin
            if (tv[i] && !picked[i] && tdl[i] <= now_ms_i) begin
              if (best < 0 || tdl[i] < tdl[best] ||
                  (tdl[i] == tdl[best] && tord[i] < tord[best]))
                best = i;
            end
          end
          if (best < 0) break;
          picked[best] = 1;
          tdl[best] = sat_add(now_ms_i, tper[best]);
          tord[best] = next_order++;
          push_result(pts_pkg::ST_DUE, tid[best], tref[best], targ[best], 0);
          due_seen++;
          n++;
        end
        if (n == 0) push_result(pts_pkg::ST_NONE, 0, 0, 0, 1);
        else expected_q[expected_q.size() - 1].last = 1;
      end
    endcase
  endtask

  // Compare one result with the oldest expectation.
  task automatic check_result();
    sched_result_t e;
    if (expected_q.size() == 0) begin
      $error("result with nothing expected: status %0d id %0h", status_o, result_id_o);
      fail_count++;
    end else begin
      e = expected_q.pop_front();
      if (status_o !== e.status) begin
        $error("status expected %0d actual %0d", e.status, status_o); fail_count++;
      end
      if (result_id_o !== e.id) begin
        $error("result_id expected %0h actual %0h", e.id, result_id_o); fail_count++;
      end
      if (due_ref_o !== e.ref_v) begin
        $error("due_ref expected %0h actual %0h", e.ref_v, due_ref_o); fail_count++;
      end
      if (due_arg_o !== e.arg) begin
        $error("due_arg expected %0h actual %0h", e.arg, due_arg_o); fail_count++;
      end
      if (last_o !== e.last) begin
        $error("last expected %0d actual %0d", e.last, last_o); fail_count++;
      end
    end
  endtask

  // Watch both channels at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TASKS; i++) tv[i] = 0;
      next_id = 1;
      next_order = 0;
      expected_q.delete();
      fail_count = 0;
      due_seen = 0;
      full_seen = 0;
    end else begin
      if (done_o) check_result();
      if (start && !busy) predict_item();
    end
  end

endmodule

// ----- dv/periodic_task_scheduler_top_tb.sv -----
// Testbench top for the periodic task scheduler: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module periodic_task_scheduler_top_tb;

  localparam int unsigned TASKS = 16;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned RAND_ITEMS = 220;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  kind_i = pts_pkg::KIND_TICK;
  logic [47:0] now_ms_i = 0;
  logic [31:0] period_ms_i = 0;
  logic        start_now_i = 0;
  logic [31:0] target_id_i = 0;
  logic [31:0] handler_ref_i = 0;
  logic [31:0] handler_arg_i = 0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [31:0] result_id_o, due_ref_o, due_arg_o;
  logic        last_o;
  int          fail_count, pending_count, due_seen, full_seen;
  int          idle_cycles;
  int          item_count;
  logic [47:0] clock_ms;
  logic [31:0] issued_ids[$];

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  periodic_task_scheduler_top #(.MAX_TASKS(TASKS)) i_dut (.*);

  periodic_task_scheduler_checker #(.MAX_TASKS(TASKS)) i_checker (.*);

  // Count cycles in which no item and no result is accepted.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Present one item and hold it until accepted; start stays up for back-to-back items.
  task automatic send_item(pts_pkg::kind_e k, logic [47:0] now, logic [31:0] per, logic sn,
                           logic [31:0] tgt, logic [31:0] r, logic [31:0] a, bit hold);
    start <= 1;
    kind_i <= k;
    now_ms_i <= now;
    period_ms_i <= per;
    start_now_i <= sn;
    target_id_i <= tgt;
    handler_ref_i <= r;
    handler_arg_i <= a;
    do @(posedge clk_i); while (busy);
    item_count++;
    if (!hold) begin
      start <= 0;
      @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_target();
    if (issued_ids.size() == 0 || $urandom_range(0, 4) == 0) return $urandom();
    return issued_ids[$urandom_range(0, issued_ids.size() - 1)];
  endfunction

  initial begin
    pts_pkg::kind_e k;
    logic [31:0] per, burst, gap;
    item_count = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed part: invalid adds, extremes, wakes, removes, full table, saturation.
    send_item(pts_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0);
    send_item(pts_pkg::KIND_ADD, 100, 0, 1, 0, 32'h1, 32'h2, 0);
    send_item(pts_pkg::KIND_ADD, 100, 5, 1, 0, 0, 32'h2, 0);
    send_item(pts_pkg::KIND_ADD, '1, '1, 0, 0, '1, '1, 0);
    send_item(pts_pkg::KIND_ADD, 10, 1, 1, 0, 32'h55, 32'hAA, 0);
    send_item(pts_pkg::KIND_ADD, 10, 1, 1, 0, 32'h66, 32'hBB, 0);
    send_item(pts_pkg::KIND_TICK, 10, '1, 1, '1, '1, '1, 0);
    send_item(pts_pkg::KIND_WAKE, 0, 0, 0, 0, 0, 0, 0);
    send_item(pts_pkg::KIND_WAKE, 0, 0, 0, 32'hDEAD, 0, 0, 0);
    send_item(pts_pkg::KIND_WAKE, 0, 0, 0, 32'd3, 0, 0, 0);
    send_item(pts_pkg::KIND_REMOVE, 0, 0, 0, 0, 0, 0, 0);
    send_item(pts_pkg::KIND_REMOVE, 0, 0, 0, 32'hBEEF, 0, 0, 0);
    send_item(pts_pkg::KIND_REMOVE, 0, 0, 0, 32'd2, 0, 0, 0);
    for (int i = 0; i < 15; i++) send_item(pts_pkg::KIND_ADD, 20, 3, 1, 0, i + 1, i, 1);
    send_item(pts_pkg::KIND_TICK, '1, 0, 0, 0, 0, 0, 0);
    send_item(pts_pkg::KIND_TICK, '1, 0, 0, 0, 0, 0, 0);
    for (int i = 1; i <= 20; i++) send_item(pts_pkg::KIND_REMOVE, 0, 0, 0, i, 0, 0, i < 20);

    // Random part: mostly adds and ticks on an advancing clock, some noise.
    clock_ms = 1000;
    issued_ids.delete();
    while (item_count < RAND_ITEMS + 50) begin
      burst = $urandom_range(1, 8);
      for (int b = 0; b < burst; b++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: k = pts_pkg::KIND_ADD;
          3: k = pts_pkg::KIND_REMOVE;
          4: k = pts_pkg::KIND_WAKE;
          default: k = pts_pkg::KIND_TICK;
        endcase
        clock_ms = clock_ms + $urandom_range(0, 20);
        per = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(1, 40);
        if ($urandom_range(0, 20) == 0) per = 0;
        send_item(k, ($urandom_range(0, 30) == 0) ? 48'({$urandom(), $urandom()}) : clock_ms,
                  per, $urandom_range(0, 1), pick_target(),
                  ($urandom_range(0, 20) == 0) ? 32'd0 : $urandom(), $urandom(),
                  b < burst - 1);
        if (k == pts_pkg::KIND_ADD) issued_ids = {issued_ids, i_checker.next_id - 32'd1};
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      repeat (gap) @(posedge clk_i);
    end

    // Drain the expectations and let the block settle.
    while (pending_count != 0) @(posedge clk_i);
    repeat (TASKS * 40) @(posedge clk_i);

    $display("Covered %0d items, %0d due results, %0d full-table rejections.",
             item_count, due_seen, full_seen);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
